@@ rtl/last_k_product_store_core_assert.svh @@
// Assertion macros used by the back end RTL (lkps_back) of the prefix product store.
`ifndef LAST_K_PRODUCT_STORE_CORE_ASSERT_SVH
`define LAST_K_PRODUCT_STORE_CORE_ASSERT_SVH

// Checked at every rising edge of clk, held off while rst is high.
`define LKPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define LKPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/lkps_pkg.sv @@
`timescale 1ns / 1ps
package lkps_pkg;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO_WIN  = 2'd1;
  localparam logic [1:0] ST_BEYOND    = 2'd2;
  localparam logic [1:0] ST_ZERO_DIV  = 2'd3;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] value;
    logic [15:0]        window_len;
  } in_t;

  typedef struct packed {
    logic signed [31:0] product;
    logic [1:0]         status;
  } out_t;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic [15:0] window_len;
  } entry_t;

endpackage

@@ rtl/lkps_front.sv @@
`timescale 1ns / 1ps
module lkps_front import lkps_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  in_t    in_data,
  output logic   q_valid,
  input  logic   q_pop,
  output entry_t q_entry
);

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  entry_t     incoming;
  logic       push;
  logic       pop;

  always_comb begin
    if (in_data.cmd == CMD_QUERY) begin
      incoming.kind = KIND_QUERY;
    end else if (in_data.value == 32'sd0) begin
      incoming.kind = KIND_CLEAR;
    end else begin
      incoming.kind = KIND_APPEND;
    end
    incoming.value      = in_data.value;
    incoming.window_len = in_data.window_len;
  end

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_entry  = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ rtl/lkps_div.sv @@
`timescale 1ns / 1ps
module lkps_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] den;
  logic        neg;
  logic [32:0] rem_sh;
  logic [32:0] diff;

  assign rem_sh   = {rem, quo[31]};
  assign diff     = rem_sh - {1'b0, den};
  assign quotient = neg ? (32'd0 - quo) : quo;

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= 32'd0;
      quo <= dividend[31] ? (32'd0 - dividend) : dividend;
      den <= divisor[31] ? (32'd0 - divisor) : divisor;
      neg <= dividend[31] ^ divisor[31];
    end else if (busy) begin
      if (!diff[32]) begin
        rem <= diff[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= rem_sh[31:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 6'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/lkps_back.sv @@
`timescale 1ns / 1ps
`include "last_k_product_store_core_assert.svh"
module lkps_back import lkps_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   q_valid,
  output logic   q_pop,
  input  entry_t q_entry,
  output logic   out_valid,
  input  logic   out_ready,
  output out_t   out_data
);

  localparam int SW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CHK  = 5'b00010,
    S_DIV  = 5'b00100,
    S_OUT  = 5'b01000,
    S_HOLD = 5'b10000
  } state_t;

  state_t      state;
  logic [31:0] ring [DEPTH];
  logic [SW-1:0] newest;
  logic [CW-1:0] held;
  logic        overrun;
  logic [31:0] newest_val;
  logic [31:0] rdata;
  logic        k_zero;
  logic        miss;
  out_t        pend;

  logic          we;
  logic [SW-1:0] waddr;
  logic [31:0]   wdata;
  logic [SW-1:0] next_slot;
  logic [31:0]   mul_lo;
  logic [SW-1:0] k_slot;
  logic [SW-1:0] back_slot;
  logic [CW-1:0] wrap_sum;
  logic          is_miss;
  logic [31:0]   divisor;
  logic          div_start;
  logic          div_done;
  logic [31:0]   div_q;

  assign next_slot = (newest == SW'(DEPTH - 1)) ? '0 : newest + SW'(1);
  assign mul_lo    = newest_val * q_entry.value;
  assign k_slot    = SW'(q_entry.window_len);
  assign wrap_sum  = CW'(newest) + CW'(DEPTH) - CW'(k_slot);
  assign back_slot = (newest >= k_slot) ? (newest - k_slot) : SW'(wrap_sum);
  assign is_miss   = 32'(q_entry.window_len) >= 32'(held);

  assign q_pop = (state == S_IDLE) && q_valid;

  // Reset seeds slot 0 with the leading 1 through the normal write port.
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = 32'd1;
    if (rst) begin
      we = 1'b1;
    end else if (q_pop && q_entry.kind == KIND_CLEAR) begin
      we = 1'b1;
    end else if (q_pop && q_entry.kind == KIND_APPEND) begin
      we    = 1'b1;
      waddr = next_slot;
      wdata = mul_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      ring[waddr] <= wdata;
    end
    rdata <= ring[back_slot];
  end

  assign divisor   = k_zero ? newest_val : rdata;
  assign div_start = (state == S_CHK) && !miss && (divisor != 32'd0);

  lkps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (newest_val),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (q_pop && q_entry.kind == KIND_QUERY) begin
      k_zero <= (q_entry.window_len == 16'd0);
      miss   <= is_miss;
    end
    if (state == S_CHK) begin
      pend.product <= '0;
      if (miss) begin
        pend.status <= overrun ? ST_BEYOND : ST_ZERO_WIN;
      end else begin
        pend.status <= ST_ZERO_DIV;
      end
    end else if (state == S_DIV && div_done) begin
      pend.product <= div_q;
      pend.status  <= ST_OK;
    end
    if (state == S_OUT && (!out_valid || out_ready)) begin
      out_data <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      newest     <= '0;
      held       <= CW'(1);
      overrun    <= 1'b0;
      newest_val <= 32'd1;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            unique case (q_entry.kind)
              KIND_CLEAR: begin
                newest     <= '0;
                held       <= CW'(1);
                overrun    <= 1'b0;
                newest_val <= 32'd1;
              end
              KIND_APPEND: begin
                newest     <= next_slot;
                newest_val <= mul_lo;
                if (held < CW'(DEPTH)) begin
                  held <= held + CW'(1);
                end else begin
                  overrun <= 1'b1;
                end
              end
              default: begin
                state <= S_CHK;
              end
            endcase
          end
        end
        S_CHK: begin
          state <= div_start ? S_DIV : S_OUT;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `LKPS_ASSERT(a_overrun_full, overrun |-> (held == CW'(DEPTH)), "overrun with ring not full")
  `LKPS_ASSERT(a_held_range, (held >= CW'(1)) && (held <= CW'(DEPTH)), "held count out of range")
  `LKPS_ASSERT(a_out_from_seq, $rose(out_valid) |-> $past(state == S_OUT), "result without query")

endmodule

@@ rtl/last_k_product_store_core.sv @@
`timescale 1ns / 1ps
// Product of the last k numbers, kept as wrapping 32-bit prefix products in a
// ring of DEPTH words since the last zero. An add is done in the back end's
// idle state; a query holds the back end through the memory read, the check,
// the one-bit-per-cycle signed divider (32 steps), the quotient capture and
// the output load. Queries that reach past the held window or hit a zero
// divisor skip the divider and go from the check to the output load. A
// two-entry queue sits in front, so items are taken while the back end works
// or a result waits. Reset writes the leading 1 into slot 0 in the reset
// cycle itself, with no further clearing pass.
module last_k_product_store_core import lkps_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic   q_valid;
  logic   q_pop;
  entry_t q_entry;

  lkps_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_entry  (q_entry)
  );

  lkps_back #(.DEPTH(DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_entry   (q_entry),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
